/* hdl/assert_macros.svh */
// assertion macros used by sdf_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define SDF_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// antecedent in this cycle implies consequent in the next
`define SDF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/sdf_pkg.sv */
// types and constants of the serial dataflash device
`default_nettype none
package sdf_pkg;

  localparam int PAGE_W = 12;
  localparam int OFF_W  = 10;

  localparam logic [1:0] PIN_CS  = 2'd0;
  localparam logic [1:0] PIN_SCK = 2'd1;
  localparam logic [1:0] PIN_SI  = 2'd2;

  localparam logic [7:0] OP_READ   = 8'h52;
  localparam logic [7:0] OP_STATUS = 8'h57;
  localparam logic [7:0] OP_CMP    = 8'h60;
  localparam logic [7:0] OP_PROG   = 8'h82;

  localparam logic [7:0] STAT_KEEP = 8'hC7;
  localparam logic [7:0] STAT_DIFF = 8'h40;
  localparam logic [7:0] ID_SMALL  = 8'h18;
  localparam logic [7:0] ID_MID    = 8'h20;
  localparam logic [7:0] ID_LARGE  = 8'h28;
  localparam logic [7:0] ERASED    = 8'hFF;

  localparam logic [3:0] CMD_DONE = 4'd8;
  localparam logic [3:0] BITS_BYTE = 4'd8;

  localparam int PB_SMALL = 264;
  localparam int PB_LARGE = 528;
  localparam int NP_SMALL = 2048;
  localparam int NP_LARGE = 4096;

  typedef enum logic [1:0] {TGT_NONE, TGT_STATUS, TGT_MAIN, TGT_BUFFER} tgt_t;
  typedef enum logic {MODE_IN, MODE_OUT} mode_t;
  typedef enum logic [1:0] {SW_NONE, SW_CMP, SW_ERASE} sweep_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_COPY, S_FETCH, S_STEP,
    S_ERASE, S_CMP, S_CMP_FIN, S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic fetch_rd;
    logic clr_wr;
    logic erase_wr;
    logic copy_rd;
    logic copy_wr;
    logic cmp_rd;
    logic cmp_acc;
    logic cmp_fin;
    logic emit;
  } ctl_t;

  typedef struct packed {
    logic             need_copy;
    logic             need_fetch;
    sweep_t           sweep;
    logic [OFF_W-1:0] pbytes;
  } sts_t;

endpackage
`default_nettype wire

/* hdl/sdf_ctrl.sv */
// controller state machine: item sequencing, page sweeps and reset clear pass
`default_nettype none
`include "assert_macros.svh"
module sdf_ctrl #(
  parameter int MAX_PAGES      = 4096,
  parameter int MAX_PAGE_BYTES = 528,
  localparam int DEPTH  = MAX_PAGES * MAX_PAGE_BYTES,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  input  wire sdf_pkg::sts_t            st,
  output sdf_pkg::ctl_t                 ctl,
  output logic [ADDR_W-1:0]             idx,
  output logic [sdf_pkg::OFF_W-1:0]     idx_d
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  sdf_pkg::state_t state_r, state_nxt;
  logic [ADDR_W-1:0]         idx_r, idx_nxt;
  logic [sdf_pkg::OFF_W-1:0] idxd_r, idxd_nxt;
  logic                      pv_r, pv_nxt;
  logic                      isd_r, isd_nxt;
  logic                      out_valid_r;
  logic                      last_pg;

  assign last_pg  = (idx_r[sdf_pkg::OFF_W-1:0] == st.pbytes - sdf_pkg::OFF_W'(1));
  assign in_stall = (state_r != sdf_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign idx   = idx_r;
  assign idx_d = idxd_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sdf_pkg::S_CLEAR:   if (idx_r == LAST_ADDR) state_nxt = sdf_pkg::S_IDLE;
      sdf_pkg::S_IDLE:    if (in_valid) state_nxt = sdf_pkg::S_DECODE;
      sdf_pkg::S_DECODE: begin
        if (st.need_copy) state_nxt = sdf_pkg::S_COPY;
        else if (st.need_fetch) state_nxt = sdf_pkg::S_FETCH;
        else state_nxt = sdf_pkg::S_STEP;
      end
      sdf_pkg::S_COPY:    if (isd_r && pv_r) state_nxt = sdf_pkg::S_STEP;
      sdf_pkg::S_FETCH:   state_nxt = sdf_pkg::S_STEP;
      sdf_pkg::S_STEP: begin
        case (st.sweep)
          sdf_pkg::SW_CMP:   state_nxt = sdf_pkg::S_CMP;
          sdf_pkg::SW_ERASE: state_nxt = sdf_pkg::S_ERASE;
          default:           state_nxt = sdf_pkg::S_DONE;
        endcase
      end
      sdf_pkg::S_ERASE:   if (last_pg) state_nxt = sdf_pkg::S_DONE;
      sdf_pkg::S_CMP:     if (isd_r && pv_r) state_nxt = sdf_pkg::S_CMP_FIN;
      sdf_pkg::S_CMP_FIN: state_nxt = sdf_pkg::S_DONE;
      sdf_pkg::S_DONE:    if (!out_valid_r || !out_stall) state_nxt = sdf_pkg::S_IDLE;
      default:            state_nxt = sdf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    idx_nxt  = idx_r;
    idxd_nxt = idxd_r;
    pv_nxt   = 1'b0;
    isd_nxt  = isd_r;
    unique case (state_r)
      sdf_pkg::S_CLEAR: begin
        ctl.clr_wr = 1'b1;
        idx_nxt = (idx_r == LAST_ADDR) ? '0 : idx_r + ADDR_W'(1);
      end
      sdf_pkg::S_IDLE:  ctl.load = in_valid;
      sdf_pkg::S_DECODE: ;
      sdf_pkg::S_COPY, sdf_pkg::S_CMP: begin
        ctl.copy_rd = (state_r == sdf_pkg::S_COPY) && !isd_r;
        ctl.copy_wr = (state_r == sdf_pkg::S_COPY) && pv_r;
        ctl.cmp_rd  = (state_r == sdf_pkg::S_CMP) && !isd_r;
        ctl.cmp_acc = (state_r == sdf_pkg::S_CMP) && pv_r;
        pv_nxt   = !isd_r;
        idxd_nxt = idx_r[sdf_pkg::OFF_W-1:0];
        if (!isd_r) begin
          if (last_pg) isd_nxt = 1'b1;
          else idx_nxt = idx_r + ADDR_W'(1);
        end else if (pv_r) begin
          isd_nxt = 1'b0;
          idx_nxt = '0;
        end
      end
      sdf_pkg::S_FETCH: ctl.fetch_rd = 1'b1;
      sdf_pkg::S_STEP:  ctl.step = 1'b1;
      sdf_pkg::S_ERASE: begin
        ctl.erase_wr = 1'b1;
        idx_nxt = last_pg ? '0 : idx_r + ADDR_W'(1);
      end
      sdf_pkg::S_CMP_FIN: ctl.cmp_fin = 1'b1;
      sdf_pkg::S_DONE:  ctl.emit = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    idxd_r <= idxd_nxt;
    if (!rst_n) begin
      state_r     <= sdf_pkg::S_CLEAR;
      idx_r       <= '0;
      pv_r        <= 1'b0;
      isd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      pv_r    <= pv_nxt;
      isd_r   <= isd_nxt;
      if (ctl.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  `SDF_ASSERT_ALWAYS(a_no_overwrite, !(ctl.emit && out_valid_r && out_stall))
  `SDF_ASSERT_ALWAYS(a_idle_clean, (state_r != sdf_pkg::S_IDLE) || (!pv_r && !isd_r))
  `SDF_ASSERT_NEXT(a_accept_decode, in_valid && !in_stall, state_r == sdf_pkg::S_DECODE)

endmodule
`default_nettype wire

/* hdl/sdf_dp.sv */
// datapath: pin state, shifters, command decoder, page buffer and main array
`default_nettype none
module sdf_dp #(
  parameter int MAX_PAGES      = 4096,
  parameter int MAX_PAGE_BYTES = 528,
  localparam int DEPTH  = MAX_PAGES * MAX_PAGE_BYTES,
  localparam int ADDR_W = $clog2(DEPTH),
  localparam int BUF_W  = $clog2(MAX_PAGE_BYTES)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     cfg_we,
  input  wire logic [1:0]               cfg_wdata,
  input  wire logic [1:0]               in_cmd,
  input  wire logic                     in_level,
  output logic                          out_serial_out,
  input  wire sdf_pkg::ctl_t            ctl,
  output sdf_pkg::sts_t                 st,
  input  wire logic [ADDR_W-1:0]        idx,
  input  wire logic [sdf_pkg::OFF_W-1:0] idx_d
);

  localparam int OW = sdf_pkg::OFF_W;
  localparam int PW = sdf_pkg::PAGE_W;
  localparam int PBL_I = (MAX_PAGE_BYTES < sdf_pkg::PB_LARGE) ? MAX_PAGE_BYTES
                                                              : sdf_pkg::PB_LARGE;
  localparam int NPL_I = (MAX_PAGES < sdf_pkg::NP_LARGE) ? MAX_PAGES : sdf_pkg::NP_LARGE;
  localparam logic [OW-1:0] PB_S = OW'(sdf_pkg::PB_SMALL);
  localparam logic [OW-1:0] PB_L = OW'(PBL_I);
  localparam logic [PW:0]   NP_S = (PW+1)'(sdf_pkg::NP_SMALL);
  localparam logic [PW:0]   NP_L = (PW+1)'(NPL_I);

  logic [7:0] main_mem [DEPTH];
  logic [7:0] buf_mem  [MAX_PAGE_BYTES];
  logic [7:0] main_q, buf_q;

  logic [1:0]       dev_r;
  logic [1:0]       cmd_r;
  logic             lvl_r;
  sdf_pkg::mode_t   mode_r, mode_nxt;
  logic [7:0]       cb_r [4];
  logic [7:0]       cb_nxt [4];
  logic [3:0]       cc_r, cc_nxt;
  logic [7:0]       status_r, status_nxt;
  sdf_pkg::tgt_t    tgt_r, tgt_nxt;
  logic [PW-1:0]    page_r, page_nxt;
  logic [OW-1:0]    off_r, off_nxt;
  logic             cs_r, cs_nxt, sck_r, sck_nxt, si_r, si_nxt, so_r, so_nxt;
  logic [7:0]       ish_r, ish_nxt, osh_r, osh_nxt;
  logic [3:0]       ibc_r, ibc_nxt, obc_r, obc_nxt;
  logic             diff_r;
  logic             sout_r;

  logic [1:0]       kind;
  logic [OW-1:0]    pb;
  logic [PW:0]      np;
  logic [PW-1:0]    page_eff;
  logic [PW+OW-1:0] base;
  logic [OW-1:0]    off_fix;
  logic [7:0]       id;
  logic             data_we;
  logic [OW-1:0]    data_addr;
  logic [7:0]       data_byte;
  sdf_pkg::sweep_t  sweep;

  logic              main_we, main_re, buf_we, buf_re;
  logic [ADDR_W-1:0] main_waddr, main_raddr;
  logic [7:0]        main_wdata, buf_wdata;
  logic [BUF_W-1:0]  buf_waddr, buf_raddr;

  function automatic logic [PW-1:0] page_mod(input logic [PW-1:0] p, input logic [PW:0] n);
    page_mod = ({1'b0, p} >= n) ? p - n[PW-1:0] : p;
  endfunction

  function automatic logic [OW-1:0] adv(input logic [OW-1:0] o, input logic [OW-1:0] lim);
    logic [OW:0] s;
    s = {1'b0, o} + (OW+1)'(1);
    adv = (s >= {1'b0, lim}) ? '0 : s[OW-1:0];
  endfunction

  assign kind = (dev_r == 2'd3) ? 2'd2 : dev_r;
  assign pb   = (kind == 2'd2) ? PB_L : PB_S;
  assign np   = (kind == 2'd0) ? NP_S : NP_L;
  assign id   = (kind == 2'd0) ? sdf_pkg::ID_SMALL :
                (kind == 2'd1) ? sdf_pkg::ID_MID : sdf_pkg::ID_LARGE;
  assign page_eff = page_mod(page_r, np);
  assign base     = page_eff * pb;
  assign off_fix  = (off_r >= pb) ? '0 : off_r;

  assign st.need_copy  = (cmd_r == sdf_pkg::PIN_CS) && lvl_r && !cs_r &&
                         (cc_r >= sdf_pkg::CMD_DONE) && (tgt_r == sdf_pkg::TGT_BUFFER);
  assign st.need_fetch = (cmd_r == sdf_pkg::PIN_SCK) && !lvl_r && sck_r &&
                         (obc_r >= sdf_pkg::BITS_BYTE) && (mode_r == sdf_pkg::MODE_OUT) &&
                         (tgt_r == sdf_pkg::TGT_MAIN);
  assign st.sweep  = sweep;
  assign st.pbytes = pb;
  assign out_serial_out = sout_r;

  always_comb begin
    logic [7:0]    b;
    logic [7:0]    op;
    logic [PW-1:0] dpage;
    logic [OW-1:0] doff;
    logic [OW-1:0] o2;
    mode_nxt = mode_r;
    for (int i = 0; i < 4; i++) cb_nxt[i] = cb_r[i];
    cc_nxt = cc_r;
    status_nxt = status_r;
    tgt_nxt = tgt_r;
    page_nxt = page_r;
    off_nxt = off_r;
    cs_nxt = cs_r;
    sck_nxt = sck_r;
    si_nxt = si_r;
    so_nxt = so_r;
    ish_nxt = ish_r;
    osh_nxt = osh_r;
    ibc_nxt = ibc_r;
    obc_nxt = obc_r;
    data_we = 1'b0;
    data_addr = '0;
    data_byte = ish_r;
    sweep = sdf_pkg::SW_NONE;
    b = '0;
    op = '0;
    dpage = '0;
    doff = '0;
    o2 = '0;
    if (ctl.step) begin
      unique case (cmd_r)
        sdf_pkg::PIN_CS: begin
          if (lvl_r != cs_r) begin
            if (lvl_r) begin
              mode_nxt = sdf_pkg::MODE_IN;
              for (int i = 0; i < 4; i++) cb_nxt[i] = '0;
              cc_nxt = '0;
              tgt_nxt = sdf_pkg::TGT_NONE;
              page_nxt = '0;
              off_nxt = '0;
              sck_nxt = 1'b0;
              si_nxt = 1'b0;
              so_nxt = 1'b0;
              ish_nxt = '0;
              ibc_nxt = '0;
              osh_nxt = '0;
              obc_nxt = '0;
              cs_nxt = 1'b1;
            end else begin
              cs_nxt = 1'b0;
            end
          end
        end
        sdf_pkg::PIN_SCK: begin
          if (lvl_r != sck_r) begin
            if (!lvl_r) begin
              if (obc_r >= sdf_pkg::BITS_BYTE) begin
                obc_nxt = '0;
                osh_nxt = '0;
                if (mode_r == sdf_pkg::MODE_OUT) begin
                  if (tgt_r == sdf_pkg::TGT_STATUS) begin
                    osh_nxt = status_r;
                  end else if (tgt_r == sdf_pkg::TGT_MAIN) begin
                    osh_nxt = main_q;
                    off_nxt = adv(off_fix, pb);
                  end
                end
              end
              ish_nxt = ish_r | (si_r ? (8'd1 << ibc_r[2:0]) : 8'd0);
              ibc_nxt = ibc_r + 4'd1;
              if (ibc_nxt >= sdf_pkg::BITS_BYTE) begin
                b = ish_nxt;
                ibc_nxt = '0;
                ish_nxt = '0;
                if (mode_r == sdf_pkg::MODE_IN) begin
                  if (cc_r >= sdf_pkg::CMD_DONE) begin
                    if (tgt_r == sdf_pkg::TGT_BUFFER) begin
                      o2 = off_fix;
                      data_we = 1'b1;
                      data_addr = o2;
                      data_byte = b;
                      off_nxt = adv(o2, pb);
                    end
                  end else begin
                    if (cc_r < 4'd4) cb_nxt[cc_r[1:0]] = b;
                    cc_nxt = cc_r + 4'd1;
                    op = cb_nxt[0];
                    case (kind)
                      2'd0:    dpage = {1'b0, cb_nxt[1][3:0], cb_nxt[2][7:1]};
                      2'd1:    dpage = {cb_nxt[1][4:0], cb_nxt[2][7:1]};
                      default: dpage = {cb_nxt[1][5:0], cb_nxt[2][7:2]};
                    endcase
                    dpage = page_mod(dpage, np);
                    doff = (kind == 2'd2) ? {cb_nxt[2][1:0], cb_nxt[3]}
                                          : {1'b0, cb_nxt[2][0], cb_nxt[3]};
                    if (doff >= pb) doff = '0;
                    unique case (op)
                      sdf_pkg::OP_STATUS: begin
                        if (cc_nxt == 4'd1) begin
                          status_nxt = (status_r & sdf_pkg::STAT_KEEP) | id;
                          tgt_nxt = sdf_pkg::TGT_STATUS;
                          mode_nxt = sdf_pkg::MODE_OUT;
                          cc_nxt = sdf_pkg::CMD_DONE;
                        end
                      end
                      sdf_pkg::OP_CMP: begin
                        if (cc_nxt == 4'd4) begin
                          page_nxt = dpage;
                          tgt_nxt = sdf_pkg::TGT_NONE;
                          mode_nxt = sdf_pkg::MODE_IN;
                          cc_nxt = sdf_pkg::CMD_DONE;
                          sweep = sdf_pkg::SW_CMP;
                        end
                      end
                      sdf_pkg::OP_READ: begin
                        if (cc_nxt == 4'd8) begin
                          page_nxt = dpage;
                          off_nxt = doff;
                          tgt_nxt = sdf_pkg::TGT_MAIN;
                          mode_nxt = sdf_pkg::MODE_OUT;
                          cc_nxt = sdf_pkg::CMD_DONE;
                        end
                      end
                      sdf_pkg::OP_PROG: begin
                        if (cc_nxt == 4'd4) begin
                          page_nxt = dpage;
                          off_nxt = doff;
                          tgt_nxt = sdf_pkg::TGT_BUFFER;
                          mode_nxt = sdf_pkg::MODE_IN;
                          cc_nxt = sdf_pkg::CMD_DONE;
                          sweep = sdf_pkg::SW_ERASE;
                        end
                      end
                      default: begin
                        cb_nxt[0] = '0;
                        cc_nxt = '0;
                      end
                    endcase
                  end
                end
              end
              so_nxt = osh_nxt[obc_nxt[2:0]];
              obc_nxt = obc_nxt + 4'd1;
              sck_nxt = 1'b0;
            end else begin
              sck_nxt = 1'b1;
            end
          end
        end
        sdf_pkg::PIN_SI: if (cs_r) si_nxt = lvl_r;
        default: ;
      endcase
    end
    if (ctl.cmp_fin) begin
      status_nxt = diff_r ? (status_r | sdf_pkg::STAT_DIFF) : (status_r & ~sdf_pkg::STAT_DIFF);
    end
  end

  always_comb begin
    main_we    = ctl.clr_wr || ctl.copy_wr;
    main_waddr = ctl.clr_wr ? idx : ADDR_W'(base + (PW+OW)'(idx_d));
    main_wdata = ctl.clr_wr ? sdf_pkg::ERASED : buf_q;
    main_re    = ctl.fetch_rd || ctl.cmp_rd;
    main_raddr = ADDR_W'(base + (PW+OW)'(ctl.fetch_rd ? off_fix : idx[OW-1:0]));
    buf_we     = (ctl.clr_wr && (idx < ADDR_W'(MAX_PAGE_BYTES))) || ctl.erase_wr || data_we;
    buf_waddr  = (ctl.clr_wr || ctl.erase_wr) ? idx[BUF_W-1:0] : data_addr[BUF_W-1:0];
    buf_wdata  = ctl.clr_wr ? 8'h00 : (ctl.erase_wr ? sdf_pkg::ERASED : data_byte);
    buf_re     = ctl.copy_rd || ctl.cmp_rd;
    buf_raddr  = idx[BUF_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (main_we) main_mem[main_waddr] <= main_wdata;
    if (main_re) main_q <= main_mem[main_raddr];
  end

  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[buf_waddr] <= buf_wdata;
    if (buf_re) buf_q <= buf_mem[buf_raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_cmd;
      lvl_r <= in_level;
    end
    if (ctl.emit) sout_r <= cs_r && so_r;
    if (!rst_n) begin
      dev_r    <= 2'd0;
      mode_r   <= sdf_pkg::MODE_IN;
      for (int i = 0; i < 4; i++) cb_r[i] <= '0;
      cc_r     <= '0;
      status_r <= '0;
      tgt_r    <= sdf_pkg::TGT_NONE;
      page_r   <= '0;
      off_r    <= '0;
      cs_r     <= 1'b0;
      sck_r    <= 1'b0;
      si_r     <= 1'b0;
      so_r     <= 1'b0;
      ish_r    <= '0;
      osh_r    <= '0;
      ibc_r    <= '0;
      obc_r    <= '0;
      diff_r   <= 1'b0;
    end else begin
      if (cfg_we) dev_r <= cfg_wdata;
      mode_r   <= mode_nxt;
      for (int i = 0; i < 4; i++) cb_r[i] <= cb_nxt[i];
      cc_r     <= cc_nxt;
      status_r <= status_nxt;
      tgt_r    <= tgt_nxt;
      page_r   <= page_nxt;
      off_r    <= off_nxt;
      cs_r     <= cs_nxt;
      sck_r    <= sck_nxt;
      si_r     <= si_nxt;
      so_r     <= so_nxt;
      ish_r    <= ish_nxt;
      osh_r    <= osh_nxt;
      ibc_r    <= ibc_nxt;
      obc_r    <= obc_nxt;
      if (ctl.step) diff_r <= 1'b0;
      else if (ctl.cmp_acc && (main_q != buf_q)) diff_r <= 1'b1;
    end
  end

endmodule
`default_nettype wire

/* hdl/serial_dataflash_device.sv */
// serial dataflash device: one pin event per input word, one pin level per output word
// words are loaded, decoded, stepped and emitted, one at a time; a falling clock that loads
// a byte from the main array adds a fetch, a program command an erase sweep of one page,
// a compare a compare sweep of one page, and a rising select that commits a program a copy
// sweep of one page; reset: synchronous, then a clear pass over the whole main array erases it
// and zeroes the page buffer; words wait until it ends, configuration writes do not
`default_nettype none
module serial_dataflash_device #(
  parameter int MAX_PAGES      = 4096,
  parameter int MAX_PAGE_BYTES = 528
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_cmd,
  input  wire logic       in_level,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            out_serial_out
);

  localparam int ADDR_W = $clog2(MAX_PAGES * MAX_PAGE_BYTES);

  sdf_pkg::ctl_t             ctl;
  sdf_pkg::sts_t             st;
  logic [ADDR_W-1:0]         idx;
  logic [sdf_pkg::OFF_W-1:0] idx_d;

  sdf_ctrl #(
    .MAX_PAGES      (MAX_PAGES),
    .MAX_PAGE_BYTES (MAX_PAGE_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .ctl       (ctl),
    .idx       (idx),
    .idx_d     (idx_d)
  );

  sdf_dp #(
    .MAX_PAGES      (MAX_PAGES),
    .MAX_PAGE_BYTES (MAX_PAGE_BYTES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_cmd         (in_cmd),
    .in_level       (in_level),
    .out_serial_out (out_serial_out),
    .ctl            (ctl),
    .st             (st),
    .idx            (idx),
    .idx_d          (idx_d)
  );

endmodule
`default_nettype wire
